@@ hdl/tic_pkg.sv @@
// ----------------------------------------------------------------------------
// tic_pkg: shared types and widths for the triangle incircle pipeline.
// Widths follow from the coordinate width and bound every value exactly.
// ----------------------------------------------------------------------------
`default_nettype none

package tic_pkg;

    // Coordinate width of every vertex, incenter and inradius field.
    localparam int COORD_W   = 32;
    // Sum of squared differences and the side length root.
    localparam int SUMSQ_W   = 2 * COORD_W + 3;
    localparam int SIDELEN_W = COORD_W + 2;
    // Doubled half perimeter and the clamped Heron factors.
    localparam int P2_W      = COORD_W + 4;
    localparam int EXC_W     = COORD_W + 3;
    // Weighted vertex products, their signed sum and its magnitude.
    localparam int WPROD_W   = 2 * COORD_W + 3;
    localparam int NUM_W     = 2 * COORD_W + 4;
    localparam int MAG_W     = 2 * COORD_W + 3;
    // Heron product, split in two halves for the multipliers.
    localparam int HALF_W    = EXC_W;
    localparam int PROD_W    = 3 * EXC_W;
    localparam int RNUM_W    = PROD_W - 2;
    // Squared inradius quotient.
    localparam int RQ_W      = 2 * COORD_W;

    // One input word: three vertices.
    typedef struct packed {
        logic signed [COORD_W-1:0] vertex1_x;
        logic signed [COORD_W-1:0] vertex1_y;
        logic signed [COORD_W-1:0] vertex2_x;
        logic signed [COORD_W-1:0] vertex2_y;
        logic signed [COORD_W-1:0] vertex3_x;
        logic signed [COORD_W-1:0] vertex3_y;
    } tic_in_t;

    // One output word: incenter, inradius and the degenerate flag.
    typedef struct packed {
        logic signed [COORD_W-1:0] incenter_x;
        logic signed [COORD_W-1:0] incenter_y;
        logic        [COORD_W-1:0] inradius;
        logic                      degenerate;
    } tic_out_t;

    // Operands handed from the combine stages to the dividers.
    typedef struct packed {
        logic [RNUM_W-1:0] rad_num;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic              neg_x;
        logic              neg_y;
        logic [P2_W-1:0]   p2;
        logic              degenerate;
    } tic_mid_t;

    // Data carried alongside the radius divider.
    typedef struct packed {
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic             neg_x;
        logic             neg_y;
        logic [P2_W-1:0]  p2;
        logic             degenerate;
    } tic_rside_t;

    // Data carried alongside the incenter divider.
    typedef struct packed {
        logic [RQ_W-1:0] rad_sq;
        logic            neg_x;
        logic            neg_y;
        logic            degenerate;
    } tic_cside_t;

    // Data carried alongside the final square root.
    typedef struct packed {
        logic signed [COORD_W-1:0] incenter_x;
        logic signed [COORD_W-1:0] incenter_y;
        logic                      degenerate;
    } tic_fside_t;

endpackage

`default_nettype wire

@@ hdl/tic_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// tic_sqrt_pipe: pipelined integer square root, one root bit per stage.
// Several lanes share the stage valid bits; a side word travels along.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_sqrt_pipe #(
    parameter int IN_W   = 67,
    parameter int LANES  = 3,
    parameter int SIDE_W = 1,
    localparam int OUT_W = (IN_W + 1) / 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][IN_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][OUT_W-1:0]    out_root,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int PAD_W = 2 * OUT_W;
    localparam int REM_W = OUT_W + 2;

    logic [OUT_W:0]      valid_w;
    logic [SIDE_W-1:0]   side_w [OUT_W+1];
    logic [PAD_W-1:0]    rad_w  [OUT_W+1][LANES];
    logic [REM_W-1:0]    rem_w  [OUT_W+1][LANES];
    logic [OUT_W-1:0]    root_w [OUT_W+1][LANES];

    // Stage zero inputs.
    assign valid_w[0] = in_valid;
    assign side_w[0]  = in_side;

    for (genvar l = 0; l < LANES; l++)
    begin : g_in
        assign rad_w[0][l]  = PAD_W'(in_rad[l]);
        assign rem_w[0][l]  = '0;
        assign root_w[0][l] = '0;
    end

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        logic              valid_reg;
        logic [SIDE_W-1:0] side_reg;

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_w[s];
            end
        end

        // Side word of this stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg <= side_w[s];
            end
        end

        assign valid_w[s+1] = valid_reg;
        assign side_w[s+1]  = side_reg;

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [REM_W-1:0] rem_shift;
            logic [REM_W-1:0] trial;
            logic             fits;
            logic [REM_W-1:0] rem_next;
            logic [REM_W-1:0] rem_reg;
            logic [OUT_W-1:0] root_next;
            logic [OUT_W-1:0] root_reg;
            logic [PAD_W-1:0] rad_next;
            logic [PAD_W-1:0] rad_reg;

            // Bring in two radicand bits and try the next root bit.
            always_comb
            begin
                rem_shift = {rem_w[s][l][REM_W-3:0], rad_w[s][l][PAD_W-1 -: 2]};
                trial     = {root_w[s][l], 2'b01};
                fits      = (rem_shift >= trial);
                rem_next  = fits ? (rem_shift - trial) : rem_shift;
                root_next = {root_w[s][l][OUT_W-2:0], fits};
                rad_next  = {rad_w[s][l][PAD_W-3:0], 2'b00};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    rad_reg  <= rad_next;
                end
            end

            assign rem_w[s+1][l]  = rem_reg;
            assign root_w[s+1][l] = root_reg;
            assign rad_w[s+1][l]  = rad_reg;
        end
    end

    // Last stage drives the outputs.
    assign out_valid = valid_w[OUT_W];
    assign out_side  = side_w[OUT_W];

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign out_root[l] = root_w[OUT_W][l];
    end

endmodule

`default_nettype wire

@@ hdl/tic_div_pipe.sv @@
// ----------------------------------------------------------------------------
// tic_div_pipe: pipelined restoring divider, one quotient bit per stage.
// The numerator divided by the divisor must stay below 2^Q_W.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_div_pipe #(
    parameter int N_W    = 67,
    parameter int D_W    = 36,
    parameter int Q_W    = 32,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][N_W-1:0]   in_num,
    input  logic [D_W-1:0]              in_den,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   out_quot,
    output logic [SIDE_W-1:0]           out_side
);

    logic [Q_W:0]        valid_w;
    logic [SIDE_W-1:0]   side_w [Q_W+1];
    logic [D_W-1:0]      den_w  [Q_W+1];
    logic [D_W-1:0]      rem_w  [Q_W+1][LANES];
    logic [Q_W-1:0]      lq_w   [Q_W+1][LANES];

    // Stage zero: the top numerator bits already lie below the divisor.
    assign valid_w[0] = in_valid;
    assign side_w[0]  = in_side;
    assign den_w[0]   = in_den;

    for (genvar l = 0; l < LANES; l++)
    begin : g_in
        assign rem_w[0][l] = D_W'(in_num[l][N_W-1:Q_W]);
        assign lq_w[0][l]  = in_num[l][Q_W-1:0];
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        logic              valid_reg;
        logic [SIDE_W-1:0] side_reg;
        logic [D_W-1:0]    den_reg;

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_w[s];
            end
        end

        // Divisor and side word of this stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg <= side_w[s];
                den_reg  <= den_w[s];
            end
        end

        assign valid_w[s+1] = valid_reg;
        assign side_w[s+1]  = side_reg;
        assign den_w[s+1]   = den_reg;

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [D_W:0]   rem_shift;
            logic           fits;
            logic [D_W-1:0] rem_next;
            logic [D_W-1:0] rem_reg;
            logic [Q_W-1:0] lq_next;
            logic [Q_W-1:0] lq_reg;

            // Shift in one numerator bit and subtract when it fits.
            // The low word shifts numerator bits out and quotient bits in.
            always_comb
            begin
                rem_shift = {rem_w[s][l], lq_w[s][l][Q_W-1]};
                fits      = (rem_shift >= {1'b0, den_w[s]});
                rem_next  = fits ? D_W'(rem_shift - {1'b0, den_w[s]}) : D_W'(rem_shift);
                lq_next   = {lq_w[s][l][Q_W-2:0], fits};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= rem_next;
                    lq_reg  <= lq_next;
                end
            end

            assign rem_w[s+1][l] = rem_reg;
            assign lq_w[s+1][l]  = lq_reg;
        end
    end

    // Last stage drives the outputs.
    assign out_valid = valid_w[Q_W];
    assign out_side  = side_w[Q_W];

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign out_quot[l] = lq_w[Q_W][l];
    end

endmodule

`default_nettype wire

@@ hdl/tic_front.sv @@
// ----------------------------------------------------------------------------
// tic_front: squared side lengths of the triangle in three stages.
// Differences, then squares, then the sum of the two squares per side.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  tic_pkg::tic_in_t                     in_vert,
    output logic                                 out_valid,
    output tic_pkg::tic_in_t                     out_vert,
    output logic [2:0][tic_pkg::SUMSQ_W-1:0]     out_sumsq
);

    import tic_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W + 2;

    logic [2:0]               valid_reg;
    tic_in_t                  vert1_reg;
    tic_in_t                  vert2_reg;
    tic_in_t                  vert3_reg;
    logic signed [DIFF_W-1:0] dx_next [3];
    logic signed [DIFF_W-1:0] dy_next [3];
    logic signed [DIFF_W-1:0] dx_reg  [3];
    logic signed [DIFF_W-1:0] dy_reg  [3];
    logic [SQ_W-1:0]          sqx_next [3];
    logic [SQ_W-1:0]          sqy_next [3];
    logic [SQ_W-1:0]          sqx_reg  [3];
    logic [SQ_W-1:0]          sqy_reg  [3];
    logic [SUMSQ_W-1:0]       sum_next [3];
    logic [SUMSQ_W-1:0]       sum_reg  [3];

    // Coordinate differences: a joins v1 and v2, b joins v2 and v3,
    // c joins v1 and v3.
    always_comb
    begin
        dx_next[0] = DIFF_W'(in_vert.vertex2_x) - DIFF_W'(in_vert.vertex1_x);
        dy_next[0] = DIFF_W'(in_vert.vertex2_y) - DIFF_W'(in_vert.vertex1_y);
        dx_next[1] = DIFF_W'(in_vert.vertex3_x) - DIFF_W'(in_vert.vertex2_x);
        dy_next[1] = DIFF_W'(in_vert.vertex3_y) - DIFF_W'(in_vert.vertex2_y);
        dx_next[2] = DIFF_W'(in_vert.vertex3_x) - DIFF_W'(in_vert.vertex1_x);
        dy_next[2] = DIFF_W'(in_vert.vertex3_y) - DIFF_W'(in_vert.vertex1_y);
    end

    // Squares of the differences, which are never negative.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqx_next[i] = dx_reg[i] * dx_reg[i];
            sqy_next[i] = dy_reg[i] * dy_reg[i];
        end
    end

    // Sum of squares per side.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = SUMSQ_W'(sqx_reg[i]) + SUMSQ_W'(sqy_reg[i]);
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vert1_reg <= in_vert;
            vert2_reg <= vert1_reg;
            vert3_reg <= vert2_reg;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            sum_reg   <= sum_next;
        end
    end

    assign out_valid    = valid_reg[2];
    assign out_vert     = vert3_reg;
    assign out_sumsq[0] = sum_reg[0];
    assign out_sumsq[1] = sum_reg[1];
    assign out_sumsq[2] = sum_reg[2];

endmodule

`default_nettype wire

@@ hdl/tic_combine.sv @@
// ----------------------------------------------------------------------------
// tic_combine: half perimeter, Heron product and weighted vertex sums.
// Four stages prepare the numerators and the divisor for the dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tic_combine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  tic_pkg::tic_in_t                      in_vert,
    input  logic [2:0][tic_pkg::SIDELEN_W-1:0]    in_len,
    output logic                                  out_valid,
    output tic_pkg::tic_mid_t                     out_mid
);

    import tic_pkg::*;

    logic [3:0]                valid_reg;

    // First stage: perimeter, clamped factors and weighted products.
    logic [P2_W-1:0]           p2_next;
    logic signed [P2_W-1:0]    ex_s;
    logic signed [P2_W-1:0]    ey_s;
    logic signed [P2_W-1:0]    ez_s;
    logic [EXC_W-1:0]          ex_next;
    logic [EXC_W-1:0]          ey_next;
    logic [EXC_W-1:0]          ez_next;
    logic signed [WPROD_W-1:0] wx_next [3];
    logic signed [WPROD_W-1:0] wy_next [3];
    logic [P2_W-1:0]           p2_1_reg;
    logic                      degen_1_reg;
    logic [EXC_W-1:0]          ex_reg;
    logic [EXC_W-1:0]          ey_reg;
    logic [EXC_W-1:0]          ez_1_reg;
    logic signed [WPROD_W-1:0] wx_reg [3];
    logic signed [WPROD_W-1:0] wy_reg [3];

    // Second stage: signed sums and the first factor product.
    logic signed [NUM_W-1:0]   num_x_next;
    logic signed [NUM_W-1:0]   num_y_next;
    logic [2*EXC_W-1:0]        exy_next;
    logic signed [NUM_W-1:0]   num_x_reg;
    logic signed [NUM_W-1:0]   num_y_reg;
    logic [2*EXC_W-1:0]        exy_reg;
    logic [EXC_W-1:0]          ez_2_reg;
    logic [P2_W-1:0]           p2_2_reg;
    logic                      degen_2_reg;

    // Third stage: magnitudes and the two partial products.
    logic [MAG_W-1:0]          mag_x_next;
    logic [MAG_W-1:0]          mag_y_next;
    logic [2*HALF_W-1:0]       part_lo_next;
    logic [2*HALF_W-1:0]       part_hi_next;
    logic [MAG_W-1:0]          mag_x_reg;
    logic [MAG_W-1:0]          mag_y_reg;
    logic                      neg_x_reg;
    logic                      neg_y_reg;
    logic [2*HALF_W-1:0]       part_lo_reg;
    logic [2*HALF_W-1:0]       part_hi_reg;
    logic [P2_W-1:0]           p2_3_reg;
    logic                      degen_3_reg;

    // Fourth stage: full Heron product over four.
    logic [PROD_W-1:0]         prod;
    tic_mid_t                  mid_next;
    tic_mid_t                  mid_reg;

    // Doubled half perimeter and the three Heron factors, clamped at zero
    // where a truncated side breaks the triangle inequality.
    always_comb
    begin
        p2_next = P2_W'(in_len[0]) + P2_W'(in_len[1]) + P2_W'(in_len[2]);
        ex_s    = $signed(P2_W'(in_len[1])) + $signed(P2_W'(in_len[2]))
                - $signed(P2_W'(in_len[0]));
        ey_s    = $signed(P2_W'(in_len[0])) + $signed(P2_W'(in_len[2]))
                - $signed(P2_W'(in_len[1]));
        ez_s    = $signed(P2_W'(in_len[0])) + $signed(P2_W'(in_len[1]))
                - $signed(P2_W'(in_len[2]));
        ex_next = ex_s[P2_W-1] ? '0 : ex_s[EXC_W-1:0];
        ey_next = ey_s[P2_W-1] ? '0 : ey_s[EXC_W-1:0];
        ez_next = ez_s[P2_W-1] ? '0 : ez_s[EXC_W-1:0];
    end

    // Vertex coordinates weighted by the opposite side lengths.
    always_comb
    begin
        wx_next[0] = $signed({1'b0, in_len[1]}) * in_vert.vertex1_x;
        wx_next[1] = $signed({1'b0, in_len[2]}) * in_vert.vertex2_x;
        wx_next[2] = $signed({1'b0, in_len[0]}) * in_vert.vertex3_x;
        wy_next[0] = $signed({1'b0, in_len[1]}) * in_vert.vertex1_y;
        wy_next[1] = $signed({1'b0, in_len[2]}) * in_vert.vertex2_y;
        wy_next[2] = $signed({1'b0, in_len[0]}) * in_vert.vertex3_y;
    end

    // Weighted sums and the product of the first two factors.
    always_comb
    begin
        num_x_next = NUM_W'(wx_reg[0]) + NUM_W'(wx_reg[1]) + NUM_W'(wx_reg[2]);
        num_y_next = NUM_W'(wy_reg[0]) + NUM_W'(wy_reg[1]) + NUM_W'(wy_reg[2]);
        exy_next   = ex_reg * ey_reg;
    end

    // Sign and magnitude of the sums; first factor product in two halves times the third.
    always_comb
    begin
        mag_x_next   = num_x_reg[NUM_W-1] ? MAG_W'(-num_x_reg) : MAG_W'(num_x_reg);
        mag_y_next   = num_y_reg[NUM_W-1] ? MAG_W'(-num_y_reg) : MAG_W'(num_y_reg);
        part_lo_next = exy_reg[HALF_W-1:0] * ez_2_reg;
        part_hi_next = exy_reg[2*HALF_W-1:HALF_W] * ez_2_reg;
    end

    // Heron product, divided by four by dropping two bits.
    always_comb
    begin
        prod                = {part_hi_reg, {HALF_W{1'b0}}} + PROD_W'(part_lo_reg);
        mid_next.rad_num    = prod[PROD_W-1:2];
        mid_next.mag_x      = mag_x_reg;
        mid_next.mag_y      = mag_y_reg;
        mid_next.neg_x      = neg_x_reg;
        mid_next.neg_y      = neg_y_reg;
        mid_next.p2         = p2_3_reg;
        mid_next.degenerate = degen_3_reg;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_1_reg    <= p2_next;
            degen_1_reg <= (p2_next == '0);
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            ez_1_reg    <= ez_next;
            wx_reg      <= wx_next;
            wy_reg      <= wy_next;

            num_x_reg   <= num_x_next;
            num_y_reg   <= num_y_next;
            exy_reg     <= exy_next;
            ez_2_reg    <= ez_1_reg;
            p2_2_reg    <= p2_1_reg;
            degen_2_reg <= degen_1_reg;

            mag_x_reg   <= mag_x_next;
            mag_y_reg   <= mag_y_next;
            neg_x_reg   <= num_x_reg[NUM_W-1];
            neg_y_reg   <= num_y_reg[NUM_W-1];
            part_lo_reg <= part_lo_next;
            part_hi_reg <= part_hi_next;
            p2_3_reg    <= p2_2_reg;
            degen_3_reg <= degen_2_reg;

            mid_reg     <= mid_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_mid   = mid_reg;

endmodule

`default_nettype wire

@@ hdl/triangle_incircle.sv @@
// ----------------------------------------------------------------------------
// triangle_incircle: incenter and inradius of a triangle in fixed point.
// Throughput is one word per cycle while the skid register is empty, set by
// the one-bit-per-stage root and divider pipelines; an output skid register
// parts the two channels.
// Reset clears all stage valid bits and the skid valid bit, nothing else.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_incircle (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vertex_valid,
    output logic               vertex_ready,
    input  tic_pkg::tic_in_t   vertex_data,
    output logic               circle_valid,
    input  logic               circle_ready,
    output tic_pkg::tic_out_t  circle_data
);

    import tic_pkg::*;

    logic                         en;
    logic                         skid_valid_reg;
    tic_out_t                     skid_reg;

    logic                         f_valid;
    tic_in_t                      f_vert;
    logic [2:0][SUMSQ_W-1:0]      f_sumsq;

    logic                         s_valid;
    logic [2:0][SIDELEN_W-1:0]    s_len;
    tic_in_t                      s_vert;

    logic                         m_valid;
    tic_mid_t                     m_mid;

    tic_rside_t                   r_side_in;
    logic                         r_valid;
    logic [0:0][RQ_W-1:0]         r_quot;
    tic_rside_t                   r_side;

    logic [1:0][MAG_W-1:0]        c_num;
    tic_cside_t                   c_side_in;
    logic                         c_valid;
    logic [1:0][COORD_W-1:0]      c_quot;
    tic_cside_t                   c_side;

    tic_fside_t                   q_side_in;
    logic                         q_valid;
    logic [0:0][COORD_W-1:0]      q_root;
    tic_fside_t                   q_side;

    tic_out_t                     pipe_data;

    // The pipeline moves whenever the skid register is empty.
    assign en           = !skid_valid_reg;
    assign vertex_ready = en;

    // Squared side lengths.
    tic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vertex_valid),
        .in_vert   (vertex_data),
        .out_valid (f_valid),
        .out_vert  (f_vert),
        .out_sumsq (f_sumsq)
    );

    // Side lengths, three lanes; the vertices ride along.
    tic_sqrt_pipe #(
        .IN_W   (SUMSQ_W),
        .LANES  (3),
        .SIDE_W ($bits(tic_in_t))
    ) u_side_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_rad    (f_sumsq),
        .in_side   (f_vert),
        .out_valid (s_valid),
        .out_root  (s_len),
        .out_side  (s_vert)
    );

    // Perimeter, Heron product and weighted sums.
    tic_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .in_vert   (s_vert),
        .in_len    (s_len),
        .out_valid (m_valid),
        .out_mid   (m_mid)
    );

    // Squared inradius: Heron product over four over the doubled perimeter.
    always_comb
    begin
        r_side_in.mag_x      = m_mid.mag_x;
        r_side_in.mag_y      = m_mid.mag_y;
        r_side_in.neg_x      = m_mid.neg_x;
        r_side_in.neg_y      = m_mid.neg_y;
        r_side_in.p2         = m_mid.p2;
        r_side_in.degenerate = m_mid.degenerate;
    end

    tic_div_pipe #(
        .N_W    (RNUM_W),
        .D_W    (P2_W),
        .Q_W    (RQ_W),
        .LANES  (1),
        .SIDE_W ($bits(tic_rside_t))
    ) u_rad_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .in_num    (m_mid.rad_num),
        .in_den    (m_mid.p2),
        .in_side   (r_side_in),
        .out_valid (r_valid),
        .out_quot  (r_quot),
        .out_side  (r_side)
    );

    // Incenter magnitudes, two lanes sharing the perimeter divisor.
    always_comb
    begin
        c_num[0]             = r_side.mag_x;
        c_num[1]             = r_side.mag_y;
        c_side_in.rad_sq     = r_quot[0];
        c_side_in.neg_x      = r_side.neg_x;
        c_side_in.neg_y      = r_side.neg_y;
        c_side_in.degenerate = r_side.degenerate;
    end

    tic_div_pipe #(
        .N_W    (MAG_W),
        .D_W    (P2_W),
        .Q_W    (COORD_W),
        .LANES  (2),
        .SIDE_W ($bits(tic_cside_t))
    ) u_ctr_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_num    (c_num),
        .in_den    (r_side.p2),
        .in_side   (c_side_in),
        .out_valid (c_valid),
        .out_quot  (c_quot),
        .out_side  (c_side)
    );

    // Restore the incenter signs; quotients truncate toward zero.
    always_comb
    begin
        q_side_in.incenter_x = c_side.neg_x ? $signed(-c_quot[0]) : $signed(c_quot[0]);
        q_side_in.incenter_y = c_side.neg_y ? $signed(-c_quot[1]) : $signed(c_quot[1]);
        q_side_in.degenerate = c_side.degenerate;
    end

    // Inradius as the root of its square.
    tic_sqrt_pipe #(
        .IN_W   (RQ_W),
        .LANES  (1),
        .SIDE_W ($bits(tic_fside_t))
    ) u_rad_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .in_rad    (c_side.rad_sq),
        .in_side   (q_side_in),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    // Coincident vertices give zeros and the degenerate flag.
    always_comb
    begin
        if (q_side.degenerate)
        begin
            pipe_data            = '0;
            pipe_data.degenerate = 1'b1;
        end
        else
        begin
            pipe_data.incenter_x = q_side.incenter_x;
            pipe_data.incenter_y = q_side.incenter_y;
            pipe_data.inradius   = q_root[0];
            pipe_data.degenerate = 1'b0;
        end
    end

    // Skid register holds a word that the output side did not take.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (circle_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (q_valid && !circle_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && q_valid && !circle_ready)
        begin
            skid_reg <= pipe_data;
        end
    end

    // Output channel.
    assign circle_valid = skid_valid_reg || q_valid;
    assign circle_data  = skid_valid_reg ? skid_reg : pipe_data;

endmodule

`default_nettype wire
